// ----- design/rti_pkg.sv -----
package rti_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W = 32;
  localparam int THR_W = 31;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int LO_W = DIFF_W;
  localparam int HI_W = CROSS_W - LO_W;
  localparam int PART_W = DIFF_W + HI_W;
  localparam int WIDE_W = 104;
  localparam int CHUNK_W = 26;
  localparam int CHUNKS = WIDE_W / CHUNK_W;
  localparam int TPART_W = THR_W + CHUNK_W;
  localparam int TLIM_W = WIDE_W + THR_W + 1;
  localparam int CMP_W = TLIM_W + 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAR_THR = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_THR = 3'd7;

  localparam logic signed [COORD_W-1:0] DIR_Z_RESET = 32'sd65536;
  localparam logic [THR_W-1:0] THR_RESET = 31'd1;

  localparam int DOT_DET = 0;
  localparam int DOT_UN = 1;
  localparam int DOT_VN = 2;
  localparam int DOT_TN = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic signed [PART_W-1:0] part_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [TPART_W-1:0] tpart_t;

endpackage

// ----- design/rti_if.sv -----
interface rti_in_if import rti_pkg::*; ();
  logic valid;
  logic ready;
  coord_t vert0_x;
  coord_t vert0_y;
  coord_t vert0_z;
  coord_t vert1_x;
  coord_t vert1_y;
  coord_t vert1_z;
  coord_t vert2_x;
  coord_t vert2_y;
  coord_t vert2_z;
  modport source (output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                  vert2_x, vert2_y, vert2_z, input ready);
  modport sink (input valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                vert2_x, vert2_y, vert2_z, output ready);
endinterface

interface rti_out_if;
  logic valid;
  logic ready;
  logic hit;
  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

interface rti_cfg_if import rti_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COORD_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/ray_triangle_intersect.sv -----
// Ray/triangle hit tester. The ray origin, direction and the two thresholds are written through
// cfg; the user must write them only while no transaction is in flight, which the block itself
// does not enforce. Each triangle transaction then yields one hit transaction. The pipeline
// takes one triangle per cycle while the result is not stalled; the depth is set by the exact
// wide dot products and the threshold product, which are cut into 33 by 34 bit and 31 by 26 bit
// partial products over separate stages. A stalled result holds the whole pipeline in place.
module ray_triangle_intersect import rti_pkg::*; (
  input  logic clk,
  input  logic rst,
  rti_cfg_if.sink cfg,
  rti_in_if.sink triangle,
  rti_out_if.source result
);

  coord_t org [3];
  coord_t dir [3];
  logic [THR_W-1:0] par_thr;
  logic [THR_W-1:0] hit_thr;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0;
      org[1] <= '0;
      org[2] <= '0;
      dir[0] <= '0;
      dir[1] <= '0;
      dir[2] <= DIR_Z_RESET;
      par_thr <= THR_RESET;
      hit_thr <= THR_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_ORIGIN_X: org[0] <= cfg.data;
        REG_ORIGIN_Y: org[1] <= cfg.data;
        REG_ORIGIN_Z: org[2] <= cfg.data;
        REG_DIR_X: dir[0] <= cfg.data;
        REG_DIR_Y: dir[1] <= cfg.data;
        REG_DIR_Z: dir[2] <= cfg.data;
        REG_PAR_THR: par_thr <= cfg.data[THR_W-1:0];
        REG_HIT_THR: hit_thr <= cfg.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, out_valid;
  logic out_hit;

  assign adv = !out_valid || result.ready;
  assign triangle.ready = adv;
  assign result.valid = out_valid;
  assign result.hit = out_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= triangle.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
      out_valid <= v9;
    end
  end

  // stage 1: edges and offset
  diff_t s1_e1 [3];
  diff_t s1_e2 [3];
  diff_t s1_s [3];
  coord_t vx0 [3];
  coord_t vx1 [3];
  coord_t vx2 [3];

  assign vx0[0] = triangle.vert0_x;
  assign vx0[1] = triangle.vert0_y;
  assign vx0[2] = triangle.vert0_z;
  assign vx1[0] = triangle.vert1_x;
  assign vx1[1] = triangle.vert1_y;
  assign vx1[2] = triangle.vert1_z;
  assign vx2[0] = triangle.vert2_x;
  assign vx2[1] = triangle.vert2_y;
  assign vx2[2] = triangle.vert2_z;

  diff_t dir_w [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dir_w[c] = diff_t'(dir[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s1_e1[c] <= diff_t'(vx1[c]) - diff_t'(vx0[c]);
        s1_e2[c] <= diff_t'(vx2[c]) - diff_t'(vx0[c]);
        s1_s[c] <= diff_t'(org[c]) - diff_t'(vx0[c]);
      end
    end
  end

  // stage 2: cross product terms
  prod_t s2_pa [3];
  prod_t s2_pb [3];
  prod_t s2_qa [3];
  prod_t s2_qb [3];
  diff_t s2_e1 [3];
  diff_t s2_e2 [3];
  diff_t s2_s [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s2_pa[c] <= dir_w[(c + 1) % 3] * s1_e2[(c + 2) % 3];
        s2_pb[c] <= dir_w[(c + 2) % 3] * s1_e2[(c + 1) % 3];
        s2_qa[c] <= s1_s[(c + 1) % 3] * s1_e1[(c + 2) % 3];
        s2_qb[c] <= s1_s[(c + 2) % 3] * s1_e1[(c + 1) % 3];
        s2_e1[c] <= s1_e1[c];
        s2_e2[c] <= s1_e2[c];
        s2_s[c] <= s1_s[c];
      end
    end
  end

  // stage 3: p = d x e2, q = s x e1
  cross_t s3_p [3];
  cross_t s3_q [3];
  diff_t s3_e1 [3];
  diff_t s3_e2 [3];
  diff_t s3_s [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s3_p[c] <= cross_t'(s2_pa[c]) - cross_t'(s2_pb[c]);
        s3_q[c] <= cross_t'(s2_qa[c]) - cross_t'(s2_qb[c]);
        s3_e1[c] <= s2_e1[c];
        s3_e2[c] <= s2_e2[c];
        s3_s[c] <= s2_s[c];
      end
    end
  end

  // stage 4: split partial products of the four dot products
  diff_t dot_a [4][3];
  cross_t dot_b [4][3];
  part_t s4_lo [4][3];
  part_t s4_hi [4][3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dot_a[DOT_DET][c] = s3_e1[c];
      dot_b[DOT_DET][c] = s3_p[c];
      dot_a[DOT_UN][c] = s3_s[c];
      dot_b[DOT_UN][c] = s3_p[c];
      dot_a[DOT_VN][c] = dir_w[c];
      dot_b[DOT_VN][c] = s3_q[c];
      dot_a[DOT_TN][c] = s3_e2[c];
      dot_b[DOT_TN][c] = s3_q[c];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        for (int c = 0; c < 3; c++) begin
          s4_lo[k][c] <= dot_a[k][c] * $signed({1'b0, dot_b[k][c][LO_W-1:0]});
          s4_hi[k][c] <= dot_a[k][c] * $signed(dot_b[k][c][CROSS_W-1:LO_W]);
        end
      end
    end
  end

  // stage 5: recombine partials
  wide_t s5_term [4][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        for (int c = 0; c < 3; c++) begin
          s5_term[k][c] <= (wide_t'(s4_hi[k][c]) <<< LO_W) + wide_t'(s4_lo[k][c]);
        end
      end
    end
  end

  // stage 6: dot product sums
  wide_t s6_dot [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        s6_dot[k] <= s5_term[k][0] + s5_term[k][1] + s5_term[k][2];
      end
    end
  end

  // stage 7: sign adjust by the determinant
  wide_t s7_det, s7_un, s7_vn, s7_tn;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s6_dot[DOT_DET] < 0) begin
        s7_det <= -s6_dot[DOT_DET];
        s7_un <= -s6_dot[DOT_UN];
        s7_vn <= -s6_dot[DOT_VN];
        s7_tn <= -s6_dot[DOT_TN];
      end else begin
        s7_det <= s6_dot[DOT_DET];
        s7_un <= s6_dot[DOT_UN];
        s7_vn <= s6_dot[DOT_VN];
        s7_tn <= s6_dot[DOT_TN];
      end
    end
  end

  // stage 8: range checks and threshold partials
  wide_t par_w;
  assign par_w = $signed({{(WIDE_W - THR_W - 2 * COORD_FRAC_BITS){1'b0}}, par_thr,
                          {(2 * COORD_FRAC_BITS){1'b0}}});

  tpart_t s8_tpart [CHUNKS];
  logic s8_ok;
  wide_t s8_uv, s8_det, s8_tn;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < CHUNKS; i++) begin
        s8_tpart[i] <= hit_thr * s7_det[CHUNK_W*i +: CHUNK_W];
      end
      s8_ok <= (s7_det != 0) && (s7_det >= par_w) && (s7_un >= 0) && (s7_un <= s7_det)
               && (s7_vn >= 0);
      s8_uv <= s7_un + s7_vn;
      s8_det <= s7_det;
      s8_tn <= s7_tn;
    end
  end

  // stage 9: threshold product and barycentric sum check
  logic [TLIM_W-1:0] tlim;
  logic [TLIM_W-1:0] s9_tlim;
  logic s9_ok;
  wide_t s9_tn;

  always_comb begin
    tlim = '0;
    for (int i = 0; i < CHUNKS; i++) begin
      tlim = tlim + (TLIM_W'(s8_tpart[i]) << (CHUNK_W * i));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_tlim <= tlim;
      s9_ok <= s8_ok && (s8_uv <= s8_det);
      s9_tn <= s8_tn;
    end
  end

  // stage 10: distance test
  logic signed [CMP_W-1:0] tn_sh;
  logic signed [CMP_W-1:0] tlim_s;
  assign tn_sh = CMP_W'(s9_tn) <<< COORD_FRAC_BITS;
  assign tlim_s = $signed({1'b0, s9_tlim});

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit <= s9_ok && (tlim_s < tn_sh);
    end
  end

  a_advance: assert property (@(posedge clk) disable iff (rst) v9 && adv |=> result.valid)
    else $error("transaction lost in final stage");
  a_reset: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");
  a_det_zero: assert property (@(posedge clk) disable iff (rst)
    v8 && adv && s8_ok |=> s9_ok || ($past(s8_uv) > $past(s8_det)))
    else $error("range check dropped");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v5) && $stable(v9))
    else $error("pipeline moved while stalled");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rti_pkg::*;

  localparam int PIPE_DEPTH = 10;
  localparam int N_RANDOM = 1250;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [255:0] big_t;

  typedef struct {
    coord_t v [9];
    logic   known;
    logic   hit;
  } tri_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rti_cfg_if cfg ();
  rti_in_if triangle ();
  rti_out_if result ();

  ray_triangle_intersect dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg.sink),
    .triangle(triangle.sink),
    .result(result.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  coord_t ray_org [3];
  coord_t ray_dir [3];
  logic [THR_W-1:0] par_thr;
  logic [THR_W-1:0] hit_thr;

  logic hit_q [$];
  int mismatches = 0;
  int cycles = 0;
  logic stall_en = 1'b0;
  tri_row_t rows [$];

  function automatic logic predict_hit(coord_t v [9]);
    big_t e1 [3], e2 [3], s [3], p [3], q [3];
    big_t det, un, vn, tn, par, tlim;
    for (int i = 0; i < 3; i++) begin
      e1[i] = big_t'(v[3 + i]) - big_t'(v[i]);
      e2[i] = big_t'(v[6 + i]) - big_t'(v[i]);
      s[i] = big_t'(ray_org[i]) - big_t'(v[i]);
    end
    p[0] = big_t'(ray_dir[1]) * e2[2] - big_t'(ray_dir[2]) * e2[1];
    p[1] = big_t'(ray_dir[2]) * e2[0] - big_t'(ray_dir[0]) * e2[2];
    p[2] = big_t'(ray_dir[0]) * e2[1] - big_t'(ray_dir[1]) * e2[0];
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
    un = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
    vn = big_t'(ray_dir[0]) * q[0] + big_t'(ray_dir[1]) * q[1] + big_t'(ray_dir[2]) * q[2];
    tn = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    if (det < 0) begin
      det = -det;
      un = -un;
      vn = -vn;
      tn = -tn;
    end
    par = big_t'({1'b0, par_thr}) <<< (2 * COORD_FRAC_BITS);
    tlim = big_t'({1'b0, hit_thr}) * det;
    if (det == 0 || det < par) return 1'b0;
    if (un < 0 || un > det) return 1'b0;
    if (vn < 0 || un + vn > det) return 1'b0;
    return (tlim < (tn <<< COORD_FRAC_BITS));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_ORIGIN_X: ray_org[0] = val;
      REG_ORIGIN_Y: ray_org[1] = val;
      REG_ORIGIN_Z: ray_org[2] = val;
      REG_DIR_X: ray_dir[0] = val;
      REG_DIR_Y: ray_dir[1] = val;
      REG_DIR_Z: ray_dir[2] = val;
      REG_PAR_THR: par_thr = val[THR_W-1:0];
      REG_HIT_THR: hit_thr = val[THR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_ray(coord_t o [3], coord_t d [3], logic [31:0] pt, logic [31:0] ht);
    write_reg(REG_ORIGIN_X, o[0]);
    write_reg(REG_ORIGIN_Y, o[1]);
    write_reg(REG_ORIGIN_Z, o[2]);
    write_reg(REG_DIR_X, d[0]);
    write_reg(REG_DIR_Y, d[1]);
    write_reg(REG_DIR_Z, d[2]);
    write_reg(REG_PAR_THR, pt);
    write_reg(REG_HIT_THR, ht);
  endtask

  task automatic send_triangle(coord_t v [9], logic known, logic hit_val);
    triangle.valid <= 1'b1;
    {triangle.vert0_x, triangle.vert0_y, triangle.vert0_z} <= {v[0], v[1], v[2]};
    {triangle.vert1_x, triangle.vert1_y, triangle.vert1_z} <= {v[3], v[4], v[5]};
    {triangle.vert2_x, triangle.vert2_y, triangle.vert2_z} <= {v[6], v[7], v[8]};
    do @(posedge clk); while (!triangle.ready);
    hit_q.push_back(known ? hit_val : predict_hit(v));
  endtask

  task automatic drain();
    while (hit_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 20) * 65536) - coord_t'(10 * 65536);
      default: return coord_t'($urandom_range(0, 65535)) - coord_t'(32768);
    endcase
  endfunction

  // mostly triangles around the ray so that hits are frequent
  task automatic random_phase(int count, int mode);
    coord_t v [9];
    coord_t c [3];
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < count; b++) begin
        if ($urandom_range(0, 9) < 7) begin
          for (int i = 0; i < 3; i++)
            c[i] = ray_org[i] + coord_t'((64'(ray_dir[i]) * $urandom_range(0, 8)) >>> 1);
          for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
              v[3 * k + i] = c[i] + (rand_coord(mode) >>> $urandom_range(0, 3));
        end else begin
          for (int i = 0; i < 9; i++) v[i] = rand_coord($urandom_range(0, 2));
        end
        send_triangle(v, 1'b0, 1'b0);
        sent++;
      end
      triangle.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
      if (result.valid && result.ready) begin
        if (hit_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected hit transaction: %0b", result.hit);
        end else begin
          logic want;
          want = hit_q.pop_front();
          if (want !== result.hit) begin
            mismatches++;
            if (mismatches <= 10) $display("hit mismatch: expected %0b got %0b", want, result.hit);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic tri_row_t mk(int a0, int a1, int a2, int b0, int b1, int b2,
                                  int c0, int c1, int c2, logic known, logic h);
    tri_row_t r;
    r.v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    r.known = known;
    r.hit = h;
    return r;
  endfunction

  initial begin
    coord_t o [3];
    coord_t d [3];
    localparam int ONE = 65536;
    localparam int MX = 32'h7fffffff;
    localparam int MN = 32'h80000000;
    ray_org = '{0, 0, 0};
    ray_dir = '{0, 0, ONE};
    par_thr = THR_RESET;
    hit_thr = THR_RESET;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    triangle.valid = 1'b0;
    {triangle.vert0_x, triangle.vert0_y, triangle.vert0_z} = '0;
    {triangle.vert1_x, triangle.vert1_y, triangle.vert1_z} = '0;
    {triangle.vert2_x, triangle.vert2_y, triangle.vert2_z} = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset ray along +z from origin
    rows.push_back(mk(-ONE, -ONE, 5*ONE, ONE, -ONE, 5*ONE, 0, ONE, 5*ONE, 1'b1, 1'b1));
    rows.push_back(mk(-ONE, -ONE, -5*ONE, ONE, -ONE, -5*ONE, 0, ONE, -5*ONE, 1'b1, 1'b0));
    rows.push_back(mk(2*ONE, 2*ONE, 5*ONE, 3*ONE, 2*ONE, 5*ONE, 2*ONE, 3*ONE, 5*ONE,
                      1'b1, 1'b0));
    rows.push_back(mk(0, 0, ONE, ONE, ONE, ONE, 2*ONE, 2*ONE, ONE, 1'b1, 1'b0));
    rows.push_back(mk(-ONE, 0, 0, ONE, 0, ONE, 0, 0, 3*ONE, 1'b1, 1'b0));
    rows.push_back(mk(0, 0, 5*ONE, ONE, 0, 5*ONE, 0, ONE, 5*ONE, 1'b0, 1'b0));
    rows.push_back(mk(MX, MX, MX, MN, MN, MN, MX, MN, MX, 1'b0, 1'b0));
    rows.push_back(mk(MN, MX, MN, MX, MN, MX, MN, MN, MX, 1'b0, 1'b0));
    rows.push_back(mk(MN, MN, MX, MX, MN, MX, 0, MX, MX, 1'b0, 1'b0));
    rows.push_back(mk(-1, -1, 1, 1, -1, 1, 0, 1, 1, 1'b0, 1'b0));
    rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
    foreach (rows[i]) send_triangle(rows[i].v, rows[i].known, rows[i].hit);
    triangle.valid <= 1'b0;
    drain();

    // zero direction, extreme origin and thresholds
    o = '{MX, MN, 0};
    d = '{0, 0, 0};
    set_ray(o, d, 32'hffffffff, 0);
    foreach (rows[i]) send_triangle(rows[i].v, 1'b1, 1'b0);
    triangle.valid <= 1'b0;
    drain();

    o = '{MN, MX, MN};
    d = '{MX, MN, MX};
    set_ray(o, d, 0, 32'h7fffffff);
    foreach (rows[i]) send_triangle(rows[i].v, 1'b0, 1'b0);
    triangle.valid <= 1'b0;
    drain();
    write_reg(REG_HIT_THR, 0);

    for (int ph = 0; ph < 6; ph++) begin
      stall_en <= ph[0];
      for (int i = 0; i < 3; i++) begin
        o[i] = rand_coord(ph % 3);
        d[i] = rand_coord(1 + ph % 2);
      end
      set_ray(o, d, (ph == 5) ? 32'h7fffffff : $urandom_range(0, 3),
              (ph == 4) ? 0 : $urandom_range(0, 2 * ONE));
      random_phase(N_RANDOM / 6, ph % 3);
      drain();
    end

    if (mismatches == 0 && hit_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
